// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Decode modes, character codes, escape mapping and hex digit decoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // decode mode of the string parser
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  // character codes
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;

  // utf-8 thresholds and lead/continuation marks
  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;
  localparam logic [2:0]  Utf8Lead2 = 3'b110;
  localparam logic [3:0]  Utf8Lead3 = 4'b1110;
  localparam logic [1:0]  Utf8Cont  = 2'b10;

  // decoded result group of one request
  typedef struct packed {
    logic [1:0] cnt;     // number of results, 0..3
    logic       has;     // 0 only for a bare end marker
    logic       last;    // final request of a string
  } dec_t;

  // byte that follows a backslash
  function automatic logic [7:0] map_escape(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      ChLowerN: r = ChLf;
      ChLowerR: r = ChCr;
      ChLowerT: r = ChTab;
      default:  r = e;
    endcase
    return r;
  endfunction

  // hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/json_string_unescape_utf8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core: JSON string body unescaper
// Decodes escapes and \u sequences of a byte stream into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Takes one raw string byte per request (tlast marks the final byte) and
// gives the decoded bytes. A request is taken every cycle while the output
// accepts and each one yields at most one result; a \u escape that ends in
// a two or three byte UTF-8 sequence, or a short \u cut off by the end of
// the string, holds the result register until all its bytes are drained,
// and the input register fills behind it. Requests pass the input register,
// the decode logic, then the result register that the output side drains.
// An end of string that yields no byte gives one result with tuser low.
module json_string_unescape_utf8_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] has_byte
  output logic       m_axis_tlast_o    // out_last
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parser state
  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [7:0]  hex_chars_q [3];
  logic        hex_wr;
  logic [15:0] code_q, code_d;
  logic        stopped_q, stopped_d;

  // decode outputs
  jsu_pkg::dec_t dec;
  logic [7:0]    dec_byte [3];

  // result register
  logic          res_valid_q;
  logic [7:0]    res_byte_q [3];
  logic [1:0]    res_top_q;
  logic [1:0]    res_idx_q;
  logic          res_has_q;
  logic          res_last_q;

  logic res_free, move, in_take;

  // decode of the registered request against the parser state
  always_comb begin
    logic [7:0]  c;
    logic [4:0]  dg;
    logic [7:0]  rb [4];
    logic        skip;
    logic [1:0]  n;
    logic [15:0] cp;
    c         = in_byte_q;
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    code_d    = code_q;
    stopped_d = stopped_q;
    hex_wr    = 1'b0;
    n         = 2'd0;
    skip      = 1'b0;
    dg        = jsu_pkg::hex_digit(c);
    cp        = 16'd0;
    dec_byte[0] = 8'd0;
    dec_byte[1] = 8'd0;
    dec_byte[2] = 8'd0;
    rb[0] = hex_chars_q[0];
    rb[1] = hex_chars_q[1];
    rb[2] = hex_chars_q[2];
    rb[3] = 8'd0;
    rb[hex_cnt_q] = c;

    unique case (mode_q)
      jsu_pkg::MODE_ESCAPE: begin
        if (c == jsu_pkg::ChLowerU) begin
          mode_d    = jsu_pkg::MODE_HEX;
          hex_cnt_d = 2'd0;
          code_d    = 16'd0;
          stopped_d = 1'b0;
        end else begin
          dec_byte[0] = jsu_pkg::map_escape(c);
          n           = 2'd1;
          mode_d      = jsu_pkg::MODE_NORMAL;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (hex_cnt_q == 2'd3 || !in_last_q) begin
          // accumulate leading hex digits
          if (!stopped_q && dg[4]) begin
            code_d = {code_q[11:0], dg[3:0]};
          end else begin
            stopped_d = 1'b1;
          end
          cp = code_d;
          if (hex_cnt_q == 2'd3) begin
            // utf-8 encoding of the code point
            if (cp < jsu_pkg::Utf8Lim1) begin
              dec_byte[0] = cp[7:0];
              n           = 2'd1;
            end else if (cp < jsu_pkg::Utf8Lim2) begin
              dec_byte[0] = {jsu_pkg::Utf8Lead2, cp[10:6]};
              dec_byte[1] = {jsu_pkg::Utf8Cont, cp[5:0]};
              n           = 2'd2;
            end else begin
              dec_byte[0] = {jsu_pkg::Utf8Lead3, cp[15:12]};
              dec_byte[1] = {jsu_pkg::Utf8Cont, cp[11:6]};
              dec_byte[2] = {jsu_pkg::Utf8Cont, cp[5:0]};
              n           = 2'd3;
            end
            mode_d    = jsu_pkg::MODE_NORMAL;
            hex_cnt_d = 2'd0;
          end else begin
            hex_wr    = 1'b1;
            hex_cnt_d = hex_cnt_q + 2'd1;
          end
        end else begin
          // short \u at end of string: re-run the collected bytes
          for (int i = 0; i < 3; i++) begin
            if (skip) begin
              skip = 1'b0;
            end else if (i <= int'(hex_cnt_q)) begin
              if (rb[i] == jsu_pkg::ChBackslash && i < int'(hex_cnt_q)) begin
                if (rb[i+1] != jsu_pkg::ChLowerU) begin
                  dec_byte[n] = jsu_pkg::map_escape(rb[i+1]);
                  n           = n + 2'd1;
                end
                skip = 1'b1;
              end else begin
                dec_byte[n] = rb[i];
                n           = n + 2'd1;
              end
            end
          end
        end
      end
      default: begin
        if (c == jsu_pkg::ChBackslash && !in_last_q) begin
          mode_d = jsu_pkg::MODE_ESCAPE;
        end else begin
          dec_byte[0] = c;
          n           = 2'd1;
        end
      end
    endcase

    // end of string: marker if nothing came out, then clear the parser
    dec.has  = 1'b1;
    dec.last = in_last_q;
    if (in_last_q) begin
      if (n == 2'd0) begin
        dec.has = 1'b0;
        n       = 2'd1;
      end
      mode_d    = jsu_pkg::MODE_NORMAL;
      hex_cnt_d = 2'd0;
      code_d    = 16'd0;
      stopped_d = 1'b0;
    end
    dec.cnt = n;
  end

  // flow control
  assign res_free = !res_valid_q || (m_axis_tready_i && res_idx_q == res_top_q);
  assign move     = in_valid_q && (dec.cnt == 2'd0 || res_free);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_valid_q || move;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= jsu_pkg::MODE_NORMAL;
      hex_cnt_q <= 2'd0;
      code_q    <= 16'd0;
      stopped_q <= 1'b0;
    end else if (move) begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      code_q    <= code_d;
      stopped_q <= stopped_d;
    end
  end

  // collected \u bytes
  always_ff @(posedge clk_i) begin
    if (move && hex_wr) begin
      hex_chars_q[hex_cnt_q] <= in_byte_q;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= 2'd0;
    end else if (move && dec.cnt != 2'd0) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= 2'd0;
    end else if (res_valid_q && m_axis_tready_i) begin
      if (res_idx_q == res_top_q) begin
        res_valid_q <= 1'b0;
      end else begin
        res_idx_q <= res_idx_q + 2'd1;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (move && dec.cnt != 2'd0) begin
      res_byte_q[0] <= dec_byte[0];
      res_byte_q[1] <= dec_byte[1];
      res_byte_q[2] <= dec_byte[2];
      res_top_q     <= dec.cnt - 2'd1;
      res_has_q     <= dec.has;
      res_last_q    <= dec.last;
    end
  end

  // output side
  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = res_byte_q[res_idx_q];
  assign m_axis_tuser_o  = res_has_q;
  assign m_axis_tlast_o  = res_last_q && (res_idx_q == res_top_q);

endmodule
